>>> rtl/rcl_pkg.sv
// Package for the ring command commit link.
// Holds item types, config register set, codes and line mask helpers.
// No dependencies.
package rcl_pkg;

    localparam int unsigned MAX_CMD_BYTES = 8;
    localparam int unsigned WORD_W        = 64;
    localparam int unsigned LEN_W         = 4;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned TIMEOUT_W     = 16;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_RX    = 2'd1;
    localparam logic [1:0] ACT_SEND  = 2'd2;
    localparam logic [1:0] ACT_FETCH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXEC_WORD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXEC_LEN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ABORT_WORD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ABORT_LEN     = 3'd4;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [LEN_W-1:0]     LEN_RESET     = 4'd1;

    typedef struct packed {
        logic [1:0]        action;
        logic [WORD_W-1:0] cmd_word;
        logic [LEN_W-1:0]  cmd_len;
    } in_item_t;

    typedef struct packed {
        logic              tx_valid;
        logic [WORD_W-1:0] tx_word;
        logic [LEN_W-1:0]  tx_len;
        logic [2:0]        link_state;
        logic              command_ready;
        logic              send_accepted;
        logic              fetch_valid;
        logic [WORD_W-1:0] fetch_word;
        logic [LEN_W-1:0]  fetch_len;
    } out_item_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_ticks;
        logic [WORD_W-1:0]    exec_word;
        logic [LEN_W-1:0]     exec_len;
        logic [WORD_W-1:0]    abort_word;
        logic [LEN_W-1:0]     abort_len;
    } cfg_t;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] n);
        logic [LEN_W-1:0] lim;
        lim = LEN_W'(MAX_CMD_BYTES);
        return (n > lim) ? lim : n;
    endfunction

    function automatic logic [WORD_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int b = 0; b < WORD_W / 8; b++)
        begin
            if (LEN_W'(b) < n)
            begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

>>> rtl/rcl_cfg.sv
// Configuration register set of the ring command commit link.
// Depends on rcl_pkg.
module rcl_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rcl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcl_pkg::WORD_W-1:0]    cfg_data,
    output rcl_pkg::cfg_t                 cfg
);
    import rcl_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
            cfg_reg.exec_word     <= '0;
            cfg_reg.exec_len      <= LEN_RESET;
            cfg_reg.abort_word    <= '0;
            cfg_reg.abort_len     <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
                REG_EXEC_WORD:     cfg_reg.exec_word     <= cfg_data;
                REG_EXEC_LEN:      cfg_reg.exec_len      <= cfg_data[LEN_W-1:0];
                REG_ABORT_WORD:    cfg_reg.abort_word    <= cfg_data;
                REG_ABORT_LEN:     cfg_reg.abort_len     <= cfg_data[LEN_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/rcl_in_stage.sv
// Input register of the ring command commit link.
// Depends on rcl_pkg.
module rcl_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rcl_pkg::in_item_t in_item,
    input  logic              take,
    output logic              item_valid,
    output rcl_pkg::in_item_t item
);
    import rcl_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/rcl_core.sv
// Commit state machine and result register of the ring command commit link.
// Depends on rcl_pkg.
module rcl_core #(
    parameter int unsigned TIMER_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rcl_pkg::cfg_t      cfg,
    input  logic               item_valid,
    input  rcl_pkg::in_item_t  item,
    output logic               take,
    output logic               out_valid,
    input  logic               out_stall,
    output rcl_pkg::out_item_t out_item
);
    import rcl_pkg::*;

    localparam int unsigned CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    typedef enum logic [2:0] {
        PH_WAIT     = 3'd0,
        PH_RECEIVED = 3'd1,
        PH_SENT     = 3'd2,
        PH_SUCCESS  = 3'd3,
        PH_ABORT    = 3'd4
    } phase_t;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [WORD_W-1:0]     held_word_reg;
    logic [WORD_W-1:0]     held_word_next;
    logic [LEN_W-1:0]      held_len_reg;
    logic [LEN_W-1:0]      held_len_next;
    logic                  ready_reg;
    logic                  ready_next;
    logic [TIMER_BITS-1:0] ticks_reg;
    logic [TIMER_BITS-1:0] ticks_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_item_t             out_item_reg;
    out_item_t             res;

    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  elen;
    logic [WORD_W-1:0] ew;
    logic [LEN_W-1:0]  alen;
    logic [WORD_W-1:0] aw;
    logic              is_abort;
    logic              is_exec;
    logic              is_held;

    assign take = item_valid && (!out_valid_reg || !out_stall);

    assign len  = sat_len(item.cmd_len);
    assign word = item.cmd_word & byte_mask(len);
    assign elen = sat_len(cfg.exec_len);
    assign ew   = cfg.exec_word & byte_mask(elen);
    assign alen = sat_len(cfg.abort_len);
    assign aw   = cfg.abort_word & byte_mask(alen);

    assign is_abort = (len == alen) && (word == aw);
    assign is_exec  = (len == elen) && (word == ew);
    assign is_held  = (len == held_len_reg) && (word == held_word_reg);

    always_comb
    begin
        logic [TIMER_BITS-1:0] ticks_inc;
        logic                  send_tx;
        logic                  send_exec;
        logic                  send_abort;

        phase_next     = phase_reg;
        held_word_next = held_word_reg;
        held_len_next  = held_len_reg;
        ready_next     = ready_reg;
        ticks_next     = ticks_reg;
        res            = '0;
        send_tx        = 1'b0;
        send_exec      = 1'b0;
        send_abort     = 1'b0;
        ticks_inc      = (ticks_reg < TMAX) ? ticks_reg + 1'b1 : ticks_reg;

        case (item.action)
            ACT_TICK:
            begin
                if (phase_reg == PH_SENT)
                begin
                    ticks_next = ticks_inc;
                    if (CMP_W'(ticks_inc) >= CMP_W'(cfg.timeout_ticks))
                    begin
                        phase_next = PH_ABORT;
                        send_abort = 1'b1;
                    end
                end
            end
            ACT_RX:
            begin
                case (phase_reg)
                    PH_WAIT:
                    begin
                        held_word_next = word;
                        held_len_next  = len;
                        send_tx        = 1'b1;
                        phase_next     = PH_RECEIVED;
                        ready_next     = 1'b0;
                        ticks_next     = '0;
                    end
                    PH_RECEIVED:
                    begin
                        if (is_abort)
                        begin
                            send_abort = 1'b1;
                            phase_next = PH_WAIT;
                            ticks_next = '0;
                        end
                        else if (is_exec)
                        begin
                            send_exec  = 1'b1;
                            ready_next = 1'b1;
                            phase_next = PH_WAIT;
                            ticks_next = '0;
                        end
                    end
                    PH_SENT:
                    begin
                        if (is_held)
                        begin
                            phase_next = PH_SUCCESS;
                            send_exec  = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_ABORT;
                            send_abort = 1'b1;
                        end
                    end
                    PH_SUCCESS:
                    begin
                        if (is_exec)
                        begin
                            ready_next = 1'b1;
                            phase_next = PH_WAIT;
                            ticks_next = '0;
                        end
                    end
                    default:
                    begin
                        if (is_abort)
                        begin
                            phase_next = PH_WAIT;
                            ticks_next = '0;
                        end
                    end
                endcase
            end
            ACT_SEND:
            begin
                if (phase_reg == PH_WAIT && len != '0)
                begin
                    send_tx           = 1'b1;
                    held_word_next    = word;
                    held_len_next     = len;
                    phase_next        = PH_SENT;
                    ready_next        = 1'b0;
                    ticks_next        = '0;
                    res.send_accepted = 1'b1;
                end
            end
            default:
            begin
                if (ready_reg)
                begin
                    res.fetch_valid = 1'b1;
                    res.fetch_word  = held_word_reg;
                    res.fetch_len   = held_len_reg;
                    ready_next      = 1'b0;
                end
            end
        endcase

        if (send_tx && len != '0)
        begin
            res.tx_valid = 1'b1;
            res.tx_word  = word;
            res.tx_len   = len;
        end
        else if (send_exec && elen != '0)
        begin
            res.tx_valid = 1'b1;
            res.tx_word  = ew;
            res.tx_len   = elen;
        end
        else if (send_abort && alen != '0)
        begin
            res.tx_valid = 1'b1;
            res.tx_word  = aw;
            res.tx_len   = alen;
        end

        res.link_state    = phase_next;
        res.command_ready = ready_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            held_word_reg <= '0;
            held_len_reg  <= '0;
            ready_reg     <= 1'b0;
            ticks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg     <= phase_next;
                held_word_reg <= held_word_next;
                held_len_reg  <= held_len_next;
                ready_reg     <= ready_next;
                ticks_reg     <= ticks_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_item_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

>>> rtl/ring_command_commit_link.sv
// Top level of the ring command commit link.
// Input channel: in_valid / in_stall with in_item (action, cmd_word, cmd_len).
// Output channel: out_valid / out_stall with out_item, one result per item.
// Config port: cfg_we, cfg_index, cfg_data; write while the block is idle.
// An accepted item lands in the input register; the commit state machine
// then evaluates it and loads the result register once that register is
// free (empty or draining); the result then waits there until taken.
// One item per cycle is sustained while out_stall is low:
// the state update is a handful of 64-bit compares in a single cycle.
// While a valid result is stalled the result register holds; an empty input
// register takes one more item, then in_stall rises until the result drains.
// Reset clears both valid flags, puts the link in wait with no held line,
// no ready command and a zero tick count, and loads the register defaults
// (timeout 1000 ticks, execute and abort words zero of length one).
// Depends on rcl_pkg, rcl_cfg, rcl_in_stage and rcl_core.
module ring_command_commit_link #(
    parameter int unsigned TIMER_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  rcl_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output rcl_pkg::out_item_t            out_item,
    input  logic                          cfg_we,
    input  logic [rcl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcl_pkg::WORD_W-1:0]    cfg_data
);
    import rcl_pkg::*;

    cfg_t     cfg;
    logic     item_valid;
    in_item_t item;
    logic     take;

    rcl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcl_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    rcl_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule
